[rtl/core/assert_macros.svh]
// assertion helpers used by source_line_classifier_top
// clk and rst_n must be in scope where these are used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SLC_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SLC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/slc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slc_pkg
// Types, character codes and helpers for the source line classifier.
// ----------------------------------------------------------------------------
package slc_pkg;

  // default counter width
  localparam int COUNT_BITS_DEF = 32;

  // field widths
  localparam int CH_W    = 8;
  localparam int MODE_W  = 2;
  localparam int OUT_W   = 32;
  localparam int TOTAL_W = 34;

  // language modes
  localparam logic [MODE_W-1:0] MODE_GENERIC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_C       = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ROFF    = 2'd2;

  // character codes
  localparam logic [CH_W-1:0] CH_HASH   = 8'h23;
  localparam logic [CH_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [CH_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [CH_W-1:0] CH_DQUOTE = 8'h22;
  localparam logic [CH_W-1:0] CH_SQUOTE = 8'h27;
  localparam logic [CH_W-1:0] CH_DOT    = 8'h2E;
  localparam logic [CH_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [CH_W-1:0] CH_NL     = 8'h0A;
  localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CH_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CH_W-1:0] CH_BS     = 8'h08;
  localparam logic [CH_W-1:0] CH_FF     = 8'h0C;
  localparam logic [CH_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CH_W-1:0] CH_VT     = 8'h0B;

  // lexer states
  typedef enum logic [3:0] {
    LEX_NORMAL,
    LEX_SLASH,
    LEX_LCOM,
    LEX_BLK,
    LEX_BLKSTAR,
    LEX_STR,
    LEX_STRESC,
    LEX_CHR,
    LEX_CHRESC,
    LEX_RSP,
    LEX_RBS,
    LEX_RCOM
  } lex_state_t;

  // whitespace in normal text does not mark a line
  function automatic logic is_space(input logic [CH_W-1:0] b);
    is_space = (b == CH_SPACE) || (b == CH_BS) || (b == CH_FF) || (b == CH_NL) ||
               (b == CH_CR) || (b == CH_TAB) || (b == CH_VT);
  endfunction

endpackage

[rtl/core/slc_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slc_in_if
// Input channel: one text byte or an end-of-file marker per word.
// ----------------------------------------------------------------------------
interface slc_in_if import slc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;
  logic            end_of_file;

  modport source (output valid, output ch, output end_of_file, input ready);
  modport sink   (input valid, input ch, input end_of_file, output ready);
endinterface

[rtl/core/slc_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slc_out_if
// Result channel: line totals, one word per end of file.
// ----------------------------------------------------------------------------
interface slc_out_if import slc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OUT_W-1:0]   code_count;
  logic [OUT_W-1:0]   comment_count;
  logic [OUT_W-1:0]   blank_count;
  logic [TOTAL_W-1:0] total_lines;

  modport source (output valid, output code_count, output comment_count,
                  output blank_count, output total_lines, input ready);
  modport sink   (input valid, input code_count, input comment_count,
                  input blank_count, input total_lines, output ready);
endinterface

[rtl/core/source_line_classifier_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_line_classifier_top
// Classifies text lines as code, comment or blank and reports the totals.
// ----------------------------------------------------------------------------
// Usage:
//   in_bus  : one text byte per word; a word with end_of_file set closes the
//             text (its ch is ignored).
//   out_bus : one word of totals per end of file: code, comment and blank line
//             counts and their sum.
//   cfg_we / cfg_wdata : language mode (0 generic, 1 C, 2 roff, 3 as generic);
//             write it only while no text is in flight.
// Throughput: one byte per cycle unless a stalled result blocks input. The
//   lexer, line flags and counters update in the cycle a byte is accepted.
// Result: totals appear on out_bus in the cycle after the end-of-file word is
//   accepted, from a single output register.
// Stall: in_bus.ready is high while the output register is empty or being
//   taken; a stalled result holds and blocks further input.
// Reset: rst_n (synchronous, active low) clears the counters, line flags,
//   lexer state and mode; after each end of file all text state clears again.
// ----------------------------------------------------------------------------
module source_line_classifier_top import slc_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  slc_in_if.sink            in_bus,
  slc_out_if.source         out_bus,
  input  logic              cfg_we,
  input  logic [MODE_W-1:0] cfg_wdata
);

  `include "assert_macros.svh"

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  // state registers
  logic [MODE_W-1:0]     mode_r;
  logic [COUNT_BITS-1:0] code_r, code_nxt;
  logic [COUNT_BITS-1:0] com_r, com_nxt;
  logic [COUNT_BITS-1:0] blank_r, blank_nxt;
  logic [TOTAL_W-1:0]    total_r, total_nxt;
  logic                  lcode_r, lcode_nxt;
  logic                  lcom_r, lcom_nxt;
  logic [1:0]            cnt_r, cnt_nxt;
  lex_state_t            lex_r, lex_nxt;

  // output register
  logic                  out_valid_r;
  logic [OUT_W-1:0]      out_code_r, out_com_r, out_blank_r;
  logic [TOTAL_W-1:0]    out_total_r;

  logic                  in_acc;
  logic                  eof_acc;
  logic                  close_line;
  logic                  close_code, close_com;
  logic                  inc_code, inc_com, inc_blank;
  logic [MODE_W-1:0]     mode;

  // handshake
  assign in_bus.ready = !out_valid_r || out_bus.ready;
  assign in_acc       = in_bus.valid && in_bus.ready;
  assign eof_acc      = in_acc && in_bus.end_of_file;

  // mode three acts as generic
  assign mode = (mode_r == MODE_C || mode_r == MODE_ROFF) ? mode_r : MODE_GENERIC;

  // lexer and line flags
  always_comb begin
    logic [CH_W-1:0] b;
    lex_state_t      st;
    logic            code_f, com_f;
    logic [1:0]      cnt;

    b          = in_bus.ch;
    st         = lex_r;
    code_f     = lcode_r;
    com_f      = lcom_r;
    cnt        = cnt_r;
    close_line = 1'b0;
    close_code = 1'b0;
    close_com  = 1'b0;

    // states left over from another mode read as normal text
    if (mode == MODE_GENERIC ||
        (mode == MODE_C && st > LEX_CHRESC) ||
        (mode == MODE_ROFF && st != LEX_NORMAL && st < LEX_RSP)) begin
      st = LEX_NORMAL;
    end

    if (in_bus.end_of_file) begin
      // pending lone slash makes the last line code
      if (mode == MODE_C && st == LEX_SLASH) begin
        code_f = 1'b1;
      end
      close_line = (cnt != 2'd0);
      close_code = code_f;
      close_com  = com_f;
      code_f     = 1'b0;
      com_f      = 1'b0;
      cnt        = 2'd0;
      st         = LEX_NORMAL;
    end else begin
      // lone slash: code on its own line, byte is lexed afresh
      if (st == LEX_SLASH && b != CH_SLASH && b != CH_STAR) begin
        code_f = 1'b1;
        st     = LEX_NORMAL;
      end

      // line end closes the line with the flags so far
      if (b == CH_NL) begin
        close_line = 1'b1;
        close_code = code_f;
        close_com  = com_f;
        code_f     = 1'b0;
        com_f      = 1'b0;
        cnt        = 2'd0;
      end else if (cnt < 2'd2) begin
        cnt = cnt + 2'd1;
      end

      unique case (st)
        LEX_NORMAL: begin
          if (!is_space(b)) begin
            if (mode == MODE_GENERIC) begin
              if (b == CH_HASH) com_f = 1'b1;
              else code_f = 1'b1;
            end else if (mode == MODE_C) begin
              if (b == CH_SLASH) begin
                st = LEX_SLASH;
              end else begin
                code_f = 1'b1;
                if (b == CH_DQUOTE) st = LEX_STR;
                else if (b == CH_SQUOTE) st = LEX_CHR;
              end
            end else begin
              code_f = 1'b1;
              if ((b == CH_DOT || b == CH_SQUOTE) && cnt == 2'd1) st = LEX_RSP;
            end
          end
        end
        LEX_SLASH: begin
          com_f = 1'b1;
          st    = (b == CH_SLASH) ? LEX_LCOM : LEX_BLK;
        end
        LEX_LCOM, LEX_RCOM: begin
          if (b == CH_NL) st = LEX_NORMAL;
        end
        LEX_BLK: begin
          com_f = 1'b1;
          if (b == CH_STAR) st = LEX_BLKSTAR;
        end
        LEX_BLKSTAR: begin
          com_f = 1'b1;
          if (b == CH_SLASH) st = LEX_NORMAL;
          else if (b != CH_STAR) st = LEX_BLK;
        end
        LEX_STR, LEX_CHR: begin
          if (b == CH_NL || b == ((st == LEX_STR) ? CH_DQUOTE : CH_SQUOTE)) begin
            st = LEX_NORMAL;
          end else begin
            code_f = 1'b1;
            if (b == CH_BSLASH) st = (st == LEX_STR) ? LEX_STRESC : LEX_CHRESC;
          end
        end
        LEX_STRESC: begin
          code_f = 1'b1;
          st     = LEX_STR;
        end
        LEX_CHRESC: begin
          code_f = 1'b1;
          st     = LEX_CHR;
        end
        LEX_RSP: begin
          if (b == CH_BSLASH) st = LEX_RBS;
          else if (b != CH_SPACE && b != CH_TAB) st = LEX_NORMAL;
        end
        LEX_RBS: begin
          if (b == CH_DQUOTE) begin
            code_f = 1'b0;
            com_f  = 1'b1;
            st     = LEX_RCOM;
          end else begin
            st = LEX_NORMAL;
          end
        end
        default: st = LEX_NORMAL;
      endcase
    end

    lcode_nxt = code_f;
    lcom_nxt  = com_f;
    cnt_nxt   = cnt;
    lex_nxt   = st;
  end

  // line counters, saturating; total follows every real increment
  always_comb begin
    logic bump;
    inc_code  = close_line && close_code;
    inc_com   = close_line && !close_code && close_com;
    inc_blank = close_line && !close_code && !close_com;
    code_nxt  = (inc_code && code_r != CNT_MAX) ? code_r + 1'b1 : code_r;
    com_nxt   = (inc_com && com_r != CNT_MAX) ? com_r + 1'b1 : com_r;
    blank_nxt = (inc_blank && blank_r != CNT_MAX) ? blank_r + 1'b1 : blank_r;
    bump      = (inc_code && code_r != CNT_MAX) || (inc_com && com_r != CNT_MAX) ||
                (inc_blank && blank_r != CNT_MAX);
    total_nxt = bump ? total_r + 1'b1 : total_r;
  end

  // mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_GENERIC;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  // text state, cleared at end of file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_r  <= '0;
      com_r   <= '0;
      blank_r <= '0;
      total_r <= '0;
      lcode_r <= 1'b0;
      lcom_r  <= 1'b0;
      cnt_r   <= 2'd0;
      lex_r   <= LEX_NORMAL;
    end else if (in_acc) begin
      lcode_r <= lcode_nxt;
      lcom_r  <= lcom_nxt;
      cnt_r   <= cnt_nxt;
      lex_r   <= lex_nxt;
      if (in_bus.end_of_file) begin
        code_r  <= '0;
        com_r   <= '0;
        blank_r <= '0;
        total_r <= '0;
      end else begin
        code_r  <= code_nxt;
        com_r   <= com_nxt;
        blank_r <= blank_nxt;
        total_r <= total_nxt;
      end
    end
  end

  // result word valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (eof_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (eof_acc) begin
      out_code_r  <= OUT_W'(code_nxt);
      out_com_r   <= OUT_W'(com_nxt);
      out_blank_r <= OUT_W'(blank_nxt);
      out_total_r <= total_nxt;
    end
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.code_count    = out_code_r;
  assign out_bus.comment_count = out_com_r;
  assign out_bus.blank_count   = out_blank_r;
  assign out_bus.total_lines   = out_total_r;

  // checks
  `SLC_ASSERT_NEXT(a_eof_gives_result, eof_acc, out_valid_r, "no result after end of file")
  `SLC_ASSERT_NEXT(a_eof_clears, eof_acc,
    code_r == '0 && com_r == '0 && blank_r == '0 && cnt_r == 2'd0 && lex_r == LEX_NORMAL,
    "text state not cleared after end of file")
  `SLC_ASSERT_IMPLY(a_total_tracks, 1'b1,
    total_r == TOTAL_W'(code_r) + TOTAL_W'(com_r) + TOTAL_W'(blank_r),
    "running total out of step with counters")

endmodule
